>>> rtl/rdt_pkg.sv
// shared types and constants of the reliable datagram tracker
// controller/datapath command and status structs, codes, reset values
package rdt_pkg;

    localparam int PENDING_DEPTH_DEF = 16;
    localparam int SEEN_DEPTH_DEF    = 64;
    localparam int MAX_RESULTS       = 16;
    localparam int RES_CW            = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0]  MAX_RETRIES_RST = 8'd3;
    localparam logic [15:0] TIMEOUT_RST     = 16'd250;

    typedef enum logic [1:0] {
        CMD_SEND = 2'd0,
        CMD_RECV = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NONE = 2'd3
    } cmd_code_t;

    typedef enum logic {
        REG_MAX_RETRIES = 1'b0,
        REG_TIMEOUT     = 1'b1
    } reg_index_t;

    typedef enum logic [3:0] {
        KIND_ASSIGNED     = 4'd0,
        KIND_SEND_CONFIRM = 4'd1,
        KIND_DELIVER      = 4'd2,
        KIND_DUPLICATE    = 4'd3,
        KIND_CONFIRMED    = 4'd4,
        KIND_UNKNOWN      = 4'd5,
        KIND_WRONG_SRC    = 4'd6,
        KIND_RETRANSMIT   = 4'd7,
        KIND_GAVE_UP      = 4'd8,
        KIND_FULL         = 4'd9
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CFIND,
        ST_CSHIFT,
        ST_SREAD,
        ST_SCMP,
        ST_SDONE,
        ST_TSCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic  capture;
        logic  produce;
        kind_t kind;
        logic  flush;
        logic  add_entry;
        logic  learn_peer;
        logic  pidx_clr;
        logic  pidx_inc;
        logic  rd_next;
        logic  shift_entry;
        logic  pend_dec;
        logic  sidx_clr;
        logic  sidx_inc;
        logic  seen_rd;
        logic  dup_clr;
        logic  dup_set;
        logic  seen_write;
        logic  retry_entry;
        logic  give_up;
        logic  n_clr;
        logic  n_inc;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_code_t cmd;
        logic      full;
        logic      learn;
        logic      confirm;
        logic      src_mismatch;
        logic      idx_end;
        logic      id_match;
        logic      shift_more;
        logic      seen_end;
        logic      seen_match;
        logic      dup;
        logic      due;
        logic      retries_zero;
        logic      n_lim;
        logic      hold_valid;
        logic      load_ok;
        logic      can_produce;
    } ctrl_sts_t;

endpackage

>>> rtl/rdt_ctrl.sv
// controller state machine of the reliable datagram tracker
// depends on rdt_pkg; drives rdt_dpath by command struct
module rdt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rdt_pkg::ctrl_sts_t sts,
    output rdt_pkg::ctrl_cmd_t cmd,
    output rdt_pkg::state_t   state
);

    rdt_pkg::state_t state_reg;
    rdt_pkg::state_t state_next;

    assign state = state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rdt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.kind   = rdt_pkg::KIND_ASSIGNED;
        case (state_reg)
            rdt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = rdt_pkg::ST_DISPATCH;
                end
            end
            rdt_pkg::ST_DISPATCH:
            begin
                case (sts.cmd)
                    rdt_pkg::CMD_SEND:
                    begin
                        cmd.produce = 1'b1;
                        if (sts.full)
                        begin
                            cmd.kind = rdt_pkg::KIND_FULL;
                        end
                        else
                        begin
                            cmd.add_entry = 1'b1;
                            cmd.kind      = rdt_pkg::KIND_ASSIGNED;
                        end
                        state_next = rdt_pkg::ST_FLUSH;
                    end
                    rdt_pkg::CMD_RECV:
                    begin
                        cmd.learn_peer = sts.learn;
                        if (!sts.learn && sts.src_mismatch)
                        begin
                            cmd.produce = 1'b1;
                            cmd.kind    = rdt_pkg::KIND_WRONG_SRC;
                            state_next  = rdt_pkg::ST_FLUSH;
                        end
                        else if (sts.confirm)
                        begin
                            cmd.pidx_clr = 1'b1;
                            state_next   = rdt_pkg::ST_CFIND;
                        end
                        else
                        begin
                            cmd.produce  = 1'b1;
                            cmd.kind     = rdt_pkg::KIND_SEND_CONFIRM;
                            cmd.sidx_clr = 1'b1;
                            cmd.dup_clr  = 1'b1;
                            state_next   = rdt_pkg::ST_SREAD;
                        end
                    end
                    rdt_pkg::CMD_TICK:
                    begin
                        cmd.pidx_clr = 1'b1;
                        cmd.n_clr    = 1'b1;
                        state_next   = rdt_pkg::ST_TSCAN;
                    end
                    default:
                    begin
                        state_next = rdt_pkg::ST_IDLE;
                    end
                endcase
            end
            rdt_pkg::ST_CFIND:
            begin
                if (sts.idx_end)
                begin
                    cmd.produce = 1'b1;
                    cmd.kind    = rdt_pkg::KIND_UNKNOWN;
                    state_next  = rdt_pkg::ST_FLUSH;
                end
                else if (sts.id_match)
                begin
                    state_next = rdt_pkg::ST_CSHIFT;
                end
                else
                begin
                    cmd.pidx_inc = 1'b1;
                end
            end
            rdt_pkg::ST_CSHIFT:
            begin
                cmd.rd_next = 1'b1;
                if (sts.shift_more)
                begin
                    cmd.shift_entry = 1'b1;
                    cmd.pidx_inc    = 1'b1;
                end
                else
                begin
                    cmd.pend_dec = 1'b1;
                    cmd.produce  = 1'b1;
                    cmd.kind     = rdt_pkg::KIND_CONFIRMED;
                    state_next   = rdt_pkg::ST_FLUSH;
                end
            end
            rdt_pkg::ST_SREAD:
            begin
                if (sts.seen_end)
                begin
                    state_next = rdt_pkg::ST_SDONE;
                end
                else
                begin
                    cmd.seen_rd = 1'b1;
                    state_next  = rdt_pkg::ST_SCMP;
                end
            end
            rdt_pkg::ST_SCMP:
            begin
                cmd.dup_set  = sts.seen_match;
                cmd.sidx_inc = 1'b1;
                state_next   = rdt_pkg::ST_SREAD;
            end
            rdt_pkg::ST_SDONE:
            begin
                if (sts.can_produce)
                begin
                    cmd.produce = 1'b1;
                    if (sts.dup)
                    begin
                        cmd.kind = rdt_pkg::KIND_DUPLICATE;
                    end
                    else
                    begin
                        cmd.seen_write = 1'b1;
                        cmd.kind       = rdt_pkg::KIND_DELIVER;
                    end
                    state_next = rdt_pkg::ST_FLUSH;
                end
            end
            rdt_pkg::ST_TSCAN:
            begin
                if (sts.idx_end || sts.n_lim)
                begin
                    state_next = rdt_pkg::ST_FLUSH;
                end
                else if (sts.due)
                begin
                    if (sts.can_produce)
                    begin
                        cmd.produce = 1'b1;
                        if (sts.retries_zero)
                        begin
                            cmd.kind    = rdt_pkg::KIND_GAVE_UP;
                            cmd.give_up = 1'b1;
                            state_next  = rdt_pkg::ST_FLUSH;
                        end
                        else
                        begin
                            cmd.kind        = rdt_pkg::KIND_RETRANSMIT;
                            cmd.retry_entry = 1'b1;
                            cmd.pidx_inc    = 1'b1;
                            cmd.n_inc       = 1'b1;
                        end
                    end
                end
                else
                begin
                    cmd.pidx_inc = 1'b1;
                end
            end
            rdt_pkg::ST_FLUSH:
            begin
                if (!sts.hold_valid)
                begin
                    state_next = rdt_pkg::ST_IDLE;
                end
                else if (sts.load_ok)
                begin
                    cmd.flush  = 1'b1;
                    state_next = rdt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rdt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/rdt_dpath.sv
// datapath of the reliable datagram tracker: config, pending table, seen ring,
// result hold stage and output register; depends on rdt_pkg
module rdt_dpath
#(
    parameter int PENDING_DEPTH = rdt_pkg::PENDING_DEPTH_DEF,
    parameter int SEEN_DEPTH    = rdt_pkg::SEEN_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  rdt_pkg::ctrl_cmd_t cmd,
    output rdt_pkg::ctrl_sts_t sts,
    input  logic               cfg_valid,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic [1:0]         command,
    input  logic [31:0]        now_ms,
    input  logic [15:0]        msg_id,
    input  logic               is_confirm,
    input  logic [31:0]        src_addr,
    input  logic [15:0]        src_port,
    input  logic               learn_source,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         kind,
    output logic [15:0]        msg_id_res,
    output logic               last
);

    localparam int PCW = $clog2(PENDING_DEPTH + 1);
    localparam int PIW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int SCW = $clog2(SEEN_DEPTH + 1);
    localparam int SIW = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;

    // captured item
    rdt_pkg::cmd_code_t cap_cmd_reg;
    logic [31:0]        cap_now_reg;
    logic [15:0]        cap_id_reg;
    logic               cap_confirm_reg;
    logic [31:0]        cap_addr_reg;
    logic [15:0]        cap_port_reg;
    logic               cap_learn_reg;

    logic [7:0]  max_ret_reg;
    logic [15:0] timeout_reg;
    logic [15:0] next_id_reg;
    logic [31:0] peer_addr_reg;
    logic [15:0] peer_port_reg;
    logic [PCW-1:0] pend_count_reg;
    logic [PCW-1:0] pidx_reg;
    logic [SCW-1:0] seen_count_reg;
    logic [SCW-1:0] sidx_reg;
    logic [SIW-1:0] wptr_reg;
    logic [rdt_pkg::RES_CW-1:0] n_reg;
    logic        dup_reg;

    logic [15:0] pend_id_reg   [PENDING_DEPTH];
    logic [7:0]  pend_ret_reg  [PENDING_DEPTH];
    logic [31:0] pend_sent_reg [PENDING_DEPTH];
    logic [15:0] seen_mem      [SEEN_DEPTH];
    logic [15:0] seen_rdata_reg;

    logic          hold_valid_reg;
    rdt_pkg::kind_t hold_kind_reg;
    logic [15:0]   hold_id_reg;
    logic          out_valid_reg;
    rdt_pkg::kind_t out_kind_reg;
    logic [15:0]   out_id_reg;
    logic          out_last_reg;

    logic [PCW-1:0] rd_idx;
    logic [PCW:0]   pidx_plus;
    logic [15:0]    rd_id;
    logic [7:0]     rd_ret;
    logic [31:0]    rd_sent;
    logic [31:0]    elapsed;
    logic [15:0]    new_id;
    logic           load_ok;

    assign pidx_plus = {1'b0, pidx_reg} + {{PCW{1'b0}}, 1'b1};
    assign rd_idx    = cmd.rd_next ? pidx_plus[PCW-1:0] : pidx_reg;
    assign rd_id     = pend_id_reg[rd_idx[PIW-1:0]];
    assign rd_ret    = pend_ret_reg[rd_idx[PIW-1:0]];
    assign rd_sent   = pend_sent_reg[rd_idx[PIW-1:0]];
    assign elapsed   = cap_now_reg - rd_sent;
    assign load_ok   = !out_valid_reg || out_ready;

    always_comb
    begin
        case (cmd.kind)
            rdt_pkg::KIND_ASSIGNED,
            rdt_pkg::KIND_FULL:       new_id = next_id_reg;
            rdt_pkg::KIND_RETRANSMIT,
            rdt_pkg::KIND_GAVE_UP:    new_id = rd_id;
            default:                  new_id = cap_id_reg;
        endcase
    end

    always_comb
    begin
        sts              = '0;
        sts.cmd          = cap_cmd_reg;
        sts.full         = pend_count_reg >= PCW'(PENDING_DEPTH);
        sts.learn        = cap_learn_reg;
        sts.confirm      = cap_confirm_reg;
        sts.src_mismatch = (peer_addr_reg != cap_addr_reg) || (peer_port_reg != cap_port_reg);
        sts.idx_end      = pidx_reg >= pend_count_reg;
        sts.id_match     = rd_id == cap_id_reg;
        sts.shift_more   = pidx_plus < {1'b0, pend_count_reg};
        sts.seen_end     = sidx_reg >= seen_count_reg;
        sts.seen_match   = seen_rdata_reg == cap_id_reg;
        sts.dup          = dup_reg;
        sts.due          = elapsed >= {16'd0, timeout_reg};
        sts.retries_zero = rd_ret == 8'd0;
        sts.n_lim        = n_reg >= rdt_pkg::RES_CW'(rdt_pkg::MAX_RESULTS);
        sts.hold_valid   = hold_valid_reg;
        sts.load_ok      = load_ok;
        sts.can_produce  = !hold_valid_reg || load_ok;
    end

    // item capture, no reset on payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cap_cmd_reg     <= rdt_pkg::cmd_code_t'(command);
            cap_now_reg     <= now_ms;
            cap_id_reg      <= msg_id;
            cap_confirm_reg <= is_confirm;
            cap_addr_reg    <= src_addr;
            cap_port_reg    <= src_port;
            cap_learn_reg   <= learn_source;
        end
    end

    // pending table
    always_ff @(posedge clk)
    begin
        if (cmd.add_entry)
        begin
            pend_id_reg[pend_count_reg[PIW-1:0]]   <= next_id_reg;
            pend_ret_reg[pend_count_reg[PIW-1:0]]  <= max_ret_reg;
            pend_sent_reg[pend_count_reg[PIW-1:0]] <= cap_now_reg;
        end
        else if (cmd.shift_entry)
        begin
            pend_id_reg[pidx_reg[PIW-1:0]]   <= rd_id;
            pend_ret_reg[pidx_reg[PIW-1:0]]  <= rd_ret;
            pend_sent_reg[pidx_reg[PIW-1:0]] <= rd_sent;
        end
        else if (cmd.retry_entry)
        begin
            pend_ret_reg[pidx_reg[PIW-1:0]]  <= rd_ret - 8'd1;
            pend_sent_reg[pidx_reg[PIW-1:0]] <= cap_now_reg;
        end
    end

    // seen ring
    always_ff @(posedge clk)
    begin
        if (cmd.seen_write)
        begin
            seen_mem[wptr_reg] <= cap_id_reg;
        end
        if (cmd.seen_rd)
        begin
            seen_rdata_reg <= seen_mem[sidx_reg[SIW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.produce)
        begin
            hold_kind_reg <= cmd.kind;
            hold_id_reg   <= new_id;
        end
        if ((cmd.produce || cmd.flush) && hold_valid_reg)
        begin
            out_kind_reg <= hold_kind_reg;
            out_id_reg   <= hold_id_reg;
            out_last_reg <= cmd.flush;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_ret_reg    <= rdt_pkg::MAX_RETRIES_RST;
            timeout_reg    <= rdt_pkg::TIMEOUT_RST;
            next_id_reg    <= '0;
            peer_addr_reg  <= '0;
            peer_port_reg  <= '0;
            pend_count_reg <= '0;
            pidx_reg       <= '0;
            seen_count_reg <= '0;
            sidx_reg       <= '0;
            wptr_reg       <= '0;
            n_reg          <= '0;
            dup_reg        <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (rdt_pkg::reg_index_t'(cfg_index))
                    rdt_pkg::REG_MAX_RETRIES: max_ret_reg <= cfg_data[7:0];
                    rdt_pkg::REG_TIMEOUT:     timeout_reg <= cfg_data;
                    default:                  timeout_reg <= timeout_reg;
                endcase
            end
            if (cmd.add_entry)
            begin
                pend_count_reg <= pend_count_reg + PCW'(1);
                next_id_reg    <= next_id_reg + 16'd1;
            end
            if (cmd.pend_dec)
            begin
                pend_count_reg <= pend_count_reg - PCW'(1);
            end
            if (cmd.learn_peer)
            begin
                peer_addr_reg <= cap_addr_reg;
                peer_port_reg <= cap_port_reg;
            end
            if (cmd.pidx_clr)
            begin
                pidx_reg <= '0;
            end
            else if (cmd.pidx_inc)
            begin
                pidx_reg <= pidx_plus[PCW-1:0];
            end
            if (cmd.sidx_clr)
            begin
                sidx_reg <= '0;
            end
            else if (cmd.sidx_inc)
            begin
                sidx_reg <= sidx_reg + SCW'(1);
            end
            if (cmd.n_clr)
            begin
                n_reg <= '0;
            end
            else if (cmd.n_inc)
            begin
                n_reg <= n_reg + rdt_pkg::RES_CW'(1);
            end
            if (cmd.dup_clr)
            begin
                dup_reg <= 1'b0;
            end
            else if (cmd.dup_set)
            begin
                dup_reg <= 1'b1;
            end
            if (cmd.seen_write)
            begin
                wptr_reg <= (wptr_reg == SIW'(SEEN_DEPTH - 1)) ? '0 : wptr_reg + SIW'(1);
                if (seen_count_reg < SCW'(SEEN_DEPTH))
                begin
                    seen_count_reg <= seen_count_reg + SCW'(1);
                end
            end
            if (cmd.give_up)
            begin
                pend_count_reg <= '0;
                seen_count_reg <= '0;
                wptr_reg       <= '0;
            end
            // output register: a new transfer overrides the take of the old one
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((cmd.produce || cmd.flush) && hold_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            if (cmd.produce)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = out_kind_reg;
    assign msg_id_res = out_id_reg;
    assign last       = out_last_reg;

endmodule

>>> rtl/reliable_datagram_tracker.sv
// top level of the reliable datagram tracker: controller plus datapath
// depends on rdt_pkg, rdt_ctrl, rdt_dpath
//
//  channel   signals                                   direction
//  in        in_valid/in_ready, command..learn_source  into block
//  out       out_valid/out_ready, kind, msg_id_res, last out of block
//  cfg       cfg_valid/cfg_ready, cfg_index, cfg_data  into block
//
// one item at a time; a send needs no walk, a confirm lookup and a tick walk the
// pending table, and receive of a new message walks the seen ring
// each result sits in a hold stage until the next result or the flush, so last can be marked
// out_ready low stalls the scan only when a further result must move out
// reset clears counters and peer and sets config to its defaults; tables need no clearing
module reliable_datagram_tracker
#(
    parameter int PENDING_DEPTH = rdt_pkg::PENDING_DEPTH_DEF,
    parameter int SEEN_DEPTH    = rdt_pkg::SEEN_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [31:0] now_ms,
    input  logic [15:0] msg_id,
    input  logic        is_confirm,
    input  logic [31:0] src_addr,
    input  logic [15:0] src_port,
    input  logic        learn_source,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  kind,
    output logic [15:0] msg_id_res,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    rdt_pkg::ctrl_cmd_t cmd;
    rdt_pkg::ctrl_sts_t sts;
    rdt_pkg::state_t    state;

    assign cfg_ready = 1'b1;

    rdt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd),
        .state    (state)
    );

    rdt_dpath
    #(
        .PENDING_DEPTH (PENDING_DEPTH),
        .SEEN_DEPTH    (SEEN_DEPTH)
    )
    u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .command      (command),
        .now_ms       (now_ms),
        .msg_id       (msg_id),
        .is_confirm   (is_confirm),
        .src_addr     (src_addr),
        .src_port     (src_port),
        .learn_source (learn_source),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .msg_id_res   (msg_id_res),
        .last         (last)
    );

    // no held result may survive into the next item
    a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !sts.hold_valid)
        else $error("held result left when idle");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while busy");

    a_flush_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> (state == rdt_pkg::ST_IDLE) && out_valid && last)
        else $error("final transfer not marked last");

endmodule
